### hw/rtl/cdsrch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsrch_pkg: shared types and constants of the clock divider search
// Word layouts, register map, divider request/response and sequencer states.
// ----------------------------------------------------------------------------
package cdsrch_pkg;

  localparam int NUM_SOURCES   = 6;
  localparam int DIVIDER_LIMIT = 255;

  localparam int RATE_W    = 32;
  localparam int DIV_W     = 8;
  localparam int SRC_IDX_W = 3;
  localparam int SRC_CNT_W = SRC_IDX_W + 1;
  localparam int MASK_W    = 6;

  // Largest even divider the stages accept
  localparam logic [DIV_W-1:0] DIV_CAP = DIV_W'(DIVIDER_LIMIT & ~1);

  // Source mask bits that name existing sources
  localparam logic [MASK_W-1:0] SRC_MASK_ALL = MASK_W'((1 << NUM_SOURCES) - 1);

  // Register map: sources first, then the bus rate
  localparam int CFG_BUS    = NUM_SOURCES;
  localparam int NUM_REGS   = NUM_SOURCES + 1;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_ADDR_W = CFG_IDX_W + 2;

  typedef logic [NUM_SOURCES-1:0][RATE_W-1:0] rate_arr_t;

  typedef struct packed {
    logic [RATE_W-1:0] requested_rate;
    logic [MASK_W-1:0] source_mask;
    logic [MASK_W-1:0] second_mask;
    logic [1:0]        stage_count;
    logic signed [3:0] forced_source;
    logic              has_bus_clock;
  } in_word_t;

  typedef struct packed {
    logic [RATE_W-1:0]    achieved_rate;
    logic                 error_flag;
    logic                 bus_path;
    logic                 stage0_used;
    logic [SRC_IDX_W-1:0] stage0_source;
    logic [DIV_W-1:0]     stage0_divider;
    logic                 stage1_from_stage0;
    logic [SRC_IDX_W-1:0] stage1_source;
    logic [DIV_W-1:0]     stage1_divider;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] dividend;
    logic [RATE_W:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_D_REQ,
    ST_D_LO,
    ST_D_UP,
    ST_D_FIN,
    ST_EVAL,
    ST_FIN,
    ST_OUT
  } seq_state_e;

  // Absolute difference of two rates
  function automatic logic [RATE_W-1:0] rate_dist(input logic [RATE_W-1:0] a,
                                                  input logic [RATE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### hw/rtl/cdsrch_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsrch_regs: configuration register file
// APB-style port holding the source rates and the bus rate.
// ----------------------------------------------------------------------------
module cdsrch_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cdsrch_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output cdsrch_pkg::rate_arr_t             src_rate_o,
  output logic [cdsrch_pkg::RATE_W-1:0]     bus_rate_o
);
  import cdsrch_pkg::*;

  rate_arr_t         src_q;
  logic [RATE_W-1:0] bus_q;
  logic [CFG_IDX_W-1:0] idx;
  logic              wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write a register at the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
      bus_q <= '0;
    end else if (wr_en) begin
      if (32'(idx) < NUM_SOURCES) begin
        src_q[idx] <= pwdata;
      end else if (32'(idx) == CFG_BUS) begin
        bus_q <= pwdata;
      end
    end
  end

  // Return the addressed register
  always_comb begin
    prdata = '0;
    if (32'(idx) < NUM_SOURCES) begin
      prdata = src_q[idx];
    end else if (32'(idx) == CFG_BUS) begin
      prdata = bus_q;
    end
  end

  assign src_rate_o = src_q;
  assign bus_rate_o = bus_q;

endmodule

### hw/rtl/cdsrch_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsrch_divider: shared iterative divider
// Restoring division, one quotient bit per cycle, 32 bits over a 33 bit divisor.
// ----------------------------------------------------------------------------
module cdsrch_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cdsrch_pkg::div_req_t  req_i,
  output cdsrch_pkg::div_rsp_t  rsp_o
);
  import cdsrch_pkg::*;

  localparam int CNT_W = $clog2(RATE_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RATE_W:0]   rem_q, rem_d;
  logic [RATE_W-1:0] dvd_q, dvd_d;
  logic [RATE_W:0]   dvs_q, dvs_d;
  logic [RATE_W+1:0] rem_sh;
  logic [RATE_W+1:0] diff;

  assign rem_sh = {rem_q, dvd_q[RATE_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  // Load on start, then shift and subtract once a cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[RATE_W+1]) begin
        rem_d = diff[RATE_W:0];
        dvd_d = {dvd_q[RATE_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[RATE_W:0];
        dvd_d = {dvd_q[RATE_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(RATE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

### hw/rtl/clock_source_divider_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_source_divider_search_core: clock source and divider search
// Sequencer that walks the clock sources through one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   Program the source rates and the bus rate over the APB-style port at
//   byte addresses 4*i. Present a request word on in_word_i and raise start
//   while busy is low; the word is taken at that edge and busy stays high
//   until the result has been shown.
//   The result word appears on result_o for one cycle, marked by
//   result_valid_o. The receiver cannot stall; result_o keeps the word until the next start.
//   A zero request or a request without sources strobes its result in
//   the cycle right after the accepting edge. Otherwise the sequencer
//   scans each source, compares each candidate in an evaluate step, and
//   runs each divider stage of a candidate as up to four divisions on the
//   one shared restoring divider; a stage whose first quotient is zero
//   takes a single division. Up to twelve candidates over both passes;
//   the item closes through the finish and output states.
//   Reset clears the configuration registers to zero and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module clock_source_divider_search_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cdsrch_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  cdsrch_pkg::in_word_t              in_word_i,
  output logic                              result_valid_o,
  output cdsrch_pkg::out_word_t             result_o
);
  import cdsrch_pkg::*;

  rate_arr_t         src_rate;
  logic [RATE_W-1:0] bus_rate;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  seq_state_e state_q, state_d;
  logic                 launch_q, launch_d;
  logic [RATE_W-1:0]    req_q, req_d;
  logic [MASK_W-1:0]    m0_q, m0_d, m1_q, m1_d;
  logic [1:0]           steps_q, steps_d;
  logic                 forced_q, forced_d;
  logic [SRC_IDX_W-1:0] fs_q, fs_d;
  logic                 pass_q, pass_d;
  logic [SRC_CNT_W-1:0] n_q, n_d;
  logic                 stage_q, stage_d;
  logic [RATE_W-1:0]    cur_q, cur_d;
  logic [RATE_W-1:0]    qe_q, qe_d;
  logic [RATE_W:0]      up_q, up_d;
  logic [RATE_W-1:0]    lo_q, lo_d;
  logic [DIV_W-1:0]     qf_q, qf_d;
  logic [RATE_W-1:0]    r_q, r_d;
  logic [DIV_W-1:0]     dv0_q, dv0_d, dv1_q, dv1_d;
  logic [RATE_W-1:0]    best_q, best_d;
  logic                 found_q, found_d;
  out_word_t            res_q, res_d;

  cdsrch_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .src_rate_o (src_rate),
    .bus_rate_o (bus_rate)
  );

  cdsrch_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Scan bounds and the current candidate
  logic [SRC_CNT_W-1:0] lo_n, hi_n;
  logic [SRC_IDX_W-1:0] idx;
  logic [MASK_W-1:0]    mask_cur;
  logic [RATE_W-1:0]    cand_rate;
  logic                 in_range, cand_ok;
  logic [1:0]           nst;

  assign lo_n     = forced_q ? {1'b0, fs_q} : '0;
  assign hi_n     = forced_q ? ({1'b0, fs_q} + 1'b1) : SRC_CNT_W'(NUM_SOURCES);
  assign idx      = n_q[SRC_IDX_W-1:0];
  assign in_range = (n_q < hi_n) && !n_q[SRC_CNT_W-1];
  assign mask_cur = (pass_q ? m1_q : m0_q) & SRC_MASK_ALL;
  assign cand_rate = (32'(idx) < NUM_SOURCES) ? src_rate[idx] : '0;
  assign cand_ok  = (32'(idx) < MASK_W) && mask_cur[idx] && (cand_rate != '0);
  assign nst      = pass_q ? 2'd1 : steps_q;

  // Stage arithmetic
  logic [RATE_W-1:0] quot;
  logic [RATE_W:0]   qsel;
  logic              lo_worse;
  logic              stage_more;
  logic              take, exact, pass_end;

  assign quot       = div_rsp.quotient;
  assign lo_worse   = rate_dist(req_q, lo_q) > rate_dist(req_q, quot);
  assign qsel       = lo_worse ? up_q : {1'b0, qe_q};
  assign stage_more = !stage_q && (nst == 2'd2);
  assign take       = !found_q || !(rate_dist(r_q, req_q) > rate_dist(best_q, req_q));
  assign exact      = (r_q == req_q);
  assign pass_end   = (found_q && (best_q == req_q)) || ((m1_q & SRC_MASK_ALL) == '0)
                      || pass_q;

  logic div_state;
  assign div_state = (state_q == ST_D_REQ) || (state_q == ST_D_LO) ||
                     (state_q == ST_D_UP) || (state_q == ST_D_FIN);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (in_word_i.requested_rate == '0 ||
              (in_word_i.source_mask & SRC_MASK_ALL) == '0) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (in_range) begin
          if (cand_ok) begin
            state_d = (nst == 2'd0) ? ST_EVAL : ST_D_REQ;
          end
        end else if (pass_end) begin
          state_d = ST_FIN;
        end
      end
      ST_D_REQ: begin
        if (div_rsp.done && launch_q) begin
          if (quot == '0) begin
            state_d = stage_more ? ST_D_REQ : ST_EVAL;
          end else begin
            state_d = ST_D_LO;
          end
        end
      end
      ST_D_LO:  if (div_rsp.done && launch_q) state_d = ST_D_UP;
      ST_D_UP:  if (div_rsp.done && launch_q) state_d = ST_D_FIN;
      ST_D_FIN: begin
        if (div_rsp.done && launch_q) begin
          state_d = stage_more ? ST_D_REQ : ST_EVAL;
        end
      end
      ST_EVAL:  state_d = (take && exact) ? ST_FIN : ST_SCAN;
      ST_FIN:   state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Divider requests
  always_comb begin
    div_req.start    = div_state && !launch_q;
    div_req.dividend = cur_q;
    case (state_q)
      ST_D_REQ: div_req.divisor = {1'b0, req_q};
      ST_D_LO:  div_req.divisor = {1'b0, qe_q};
      ST_D_UP:  div_req.divisor = up_q;
      ST_D_FIN: div_req.divisor = {{(RATE_W + 1 - DIV_W){1'b0}}, qf_q};
      default:  div_req.divisor = {1'b0, req_q};
    endcase
  end

  // Datapath updates per state
  always_comb begin
    launch_d = launch_q;
    req_d    = req_q;
    m0_d     = m0_q;
    m1_d     = m1_q;
    steps_d  = steps_q;
    forced_d = forced_q;
    fs_d     = fs_q;
    pass_d   = pass_q;
    n_d      = n_q;
    stage_d  = stage_q;
    cur_d    = cur_q;
    qe_d     = qe_q;
    up_d     = up_q;
    lo_d     = lo_q;
    qf_d     = qf_q;
    r_d      = r_q;
    dv0_d    = dv0_q;
    dv1_d    = dv1_q;
    best_d   = best_q;
    found_d  = found_q;
    res_d    = res_q;

    if (div_req.start) begin
      launch_d = 1'b1;
    end else if (div_rsp.done) begin
      launch_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d    = in_word_i.requested_rate;
          m0_d     = in_word_i.source_mask;
          m1_d     = in_word_i.second_mask;
          steps_d  = (in_word_i.stage_count == 2'd3) ? 2'd2 : in_word_i.stage_count;
          forced_d = !in_word_i.forced_source[3];
          fs_d     = in_word_i.forced_source[SRC_IDX_W-1:0];
          pass_d   = 1'b0;
          n_d      = !in_word_i.forced_source[3] ?
                     {1'b0, in_word_i.forced_source[SRC_IDX_W-1:0]} : '0;
          found_d  = 1'b0;
          best_d   = '0;
          dv0_d    = '0;
          dv1_d    = '0;
          launch_d = 1'b0;
          res_d    = '0;
          if (in_word_i.requested_rate == '0) begin
            res_d.error_flag = 1'b1;
          end else if ((in_word_i.source_mask & SRC_MASK_ALL) == '0) begin
            res_d.achieved_rate = in_word_i.has_bus_clock ? bus_rate : '0;
            res_d.error_flag    = !in_word_i.has_bus_clock || (bus_rate == '0);
            res_d.bus_path      = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (in_range) begin
          if (cand_ok) begin
            cur_d   = cand_rate;
            r_d     = cand_rate;
            stage_d = 1'b0;
          end else begin
            n_d = n_q + 1'b1;
          end
        end else if (!pass_end) begin
          pass_d = 1'b1;
          n_d    = lo_n;
        end
      end
      ST_D_REQ: begin
        if (div_rsp.done && launch_q) begin
          if (quot == '0) begin
            // Quotient zero: pass the rate through with divider one
            if (stage_q) dv1_d = DIV_W'(1);
            else         dv0_d = DIV_W'(1);
            r_d = cur_q;
            if (stage_more) stage_d = 1'b1;
          end else begin
            qe_d = (quot == RATE_W'(1)) ? quot : {quot[RATE_W-1:1], 1'b0};
            up_d = {1'b0, quot[RATE_W-1:1], 1'b0} + (RATE_W + 1)'(2);
          end
        end
      end
      ST_D_LO: begin
        if (div_rsp.done && launch_q) lo_d = quot;
      end
      ST_D_UP: begin
        if (div_rsp.done && launch_q) begin
          qf_d = (qsel > {{(RATE_W + 1 - DIV_W){1'b0}}, DIV_CAP}) ? DIV_CAP
                                                                  : qsel[DIV_W-1:0];
        end
      end
      ST_D_FIN: begin
        if (div_rsp.done && launch_q) begin
          if (stage_q) dv1_d = qf_q;
          else         dv0_d = qf_q;
          r_d   = quot;
          cur_d = quot;
          if (stage_more) stage_d = 1'b1;
        end
      end
      ST_EVAL: begin
        if (take) begin
          found_d = 1'b1;
          best_d  = r_q;
          if (!pass_q) begin
            res_d.stage0_used        = 1'b1;
            res_d.stage0_source      = idx;
            res_d.stage0_divider     = dv0_q;
            res_d.stage1_from_stage0 = 1'b1;
            res_d.stage1_source      = '0;
            res_d.stage1_divider     = dv1_q;
          end else begin
            res_d.stage0_used        = 1'b0;
            res_d.stage0_source      = '0;
            res_d.stage0_divider     = '0;
            res_d.stage1_from_stage0 = 1'b0;
            res_d.stage1_source      = idx;
            res_d.stage1_divider     = dv0_q;
          end
        end
        if (!(take && exact)) n_d = n_q + 1'b1;
      end
      ST_FIN: begin
        res_d.achieved_rate = found_q ? best_q : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    m0_q     <= m0_d;
    m1_q     <= m1_d;
    steps_q  <= steps_d;
    forced_q <= forced_d;
    fs_q     <= fs_d;
    pass_q   <= pass_d;
    n_q      <= n_d;
    stage_q  <= stage_d;
    cur_q    <= cur_d;
    qe_q     <= qe_d;
    up_q     <= up_d;
    lo_q     <= lo_d;
    qf_q     <= qf_d;
    r_q      <= r_d;
    dv0_q    <= dv0_d;
    dv1_q    <= dv1_d;
    best_q   <= best_d;
    found_q  <= found_d;
    res_q    <= res_d;
  end

  // Drive the handshake and result
  always_comb begin
    busy           = (state_q != ST_IDLE);
    result_valid_o = (state_q == ST_OUT);
    result_o       = res_q;
  end

  // Check the handshake, the result strobe and sequencing against the divider
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_rsp.done && launch_q) |-> div_state)
    else $error("divider answered outside a divide step");

  a_launch_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_req.start)
    else $error("divider launched twice in a row");

endmodule
